FILE: rtl/hsl2rgb_pkg.sv
// Shared widths, constants and types for the HSL to RGB converter.
`default_nettype none
package hsl2rgb_pkg;

  localparam int unsigned HUE_W = 15;
  localparam int unsigned Q_W   = 13;
  localparam int unsigned CH_W  = 8;

  // One full turn and one 60 degree sector in 1/64 degree units.
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [11:0]      HUE_SECTOR = 12'd3840;
  localparam logic [Q_W-1:0]   Q_ONE      = 13'd4096;

  // Chroma carries 24 fraction bits; 1.0 needs the extra bit.
  localparam int unsigned C24_W  = 25;
  localparam int unsigned TERM_W = 37;
  localparam int unsigned MN_W   = 38;
  localparam int unsigned NUM_W  = 39;
  localparam int unsigned PROD_W = 48;
  localparam int unsigned Q15_W  = 12;

  // Scale factors for the numerators over the common denominator 2^33 * 15.
  localparam logic [TERM_W-1:0] CHROMA_K = 37'd7680;
  localparam logic [TERM_W-1:0] HALF_K   = 37'd3840;
  localparam logic [TERM_W-1:0] LIGHT_K  = 37'd31457280;

  // The byte is floor(q / 15); q below 4096 lets the reciprocal be exact.
  localparam logic [Q15_W-1:0] Q15_MAX = 12'd3840;
  localparam logic [12:0]      RECIP15 = 13'd4370;
  localparam int unsigned      SCALE_SHIFT = 33;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL   = 3'd0,
    SEC_YEL_GRN   = 3'd1,
    SEC_GRN_CYAN  = 3'd2,
    SEC_CYAN_BLUE = 3'd3,
    SEC_BLUE_MAG  = 3'd4,
    SEC_MAG_RED   = 3'd5
  } sector_t;

endpackage
`default_nettype wire

FILE: rtl/hsl2rgb_chan.sv
// Two pipeline stages that scale one channel numerator to a byte.
`default_nettype none
module hsl2rgb_chan (
  input  wire logic                             clk,
  input  wire hsl2rgb_pkg::num_t                num,
  output      logic [hsl2rgb_pkg::CH_W-1:0]     chan
);

  logic signed [hsl2rgb_pkg::PROD_W-1:0] prod;
  logic [hsl2rgb_pkg::HUE_W-1:0]         hi;
  logic [hsl2rgb_pkg::Q15_W-1:0]         q_next;
  logic [hsl2rgb_pkg::Q15_W-1:0]         q;
  logic [24:0]                           recip_prod;
  logic [hsl2rgb_pkg::CH_W-1:0]          chan_next;

  // 255 * num as a shift and subtract; then drop the power-of-two part of the divisor.
  always_comb begin
    prod = (hsl2rgb_pkg::PROD_W'(num) <<< 8) - hsl2rgb_pkg::PROD_W'(num);
    hi   = prod[hsl2rgb_pkg::SCALE_SHIFT + hsl2rgb_pkg::HUE_W - 1:hsl2rgb_pkg::SCALE_SHIFT];
    if (num[hsl2rgb_pkg::NUM_W-1] || (num == '0)) begin
      q_next = '0;
    end else if (hi >= hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::Q15_MAX)) begin
      q_next = hsl2rgb_pkg::Q15_MAX;
    end else begin
      q_next = hi[hsl2rgb_pkg::Q15_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // Remaining divide by 15 through a reciprocal, with saturation at 255.
  always_comb begin
    recip_prod = 25'(q) * 25'(hsl2rgb_pkg::RECIP15);
    if (q >= hsl2rgb_pkg::Q15_MAX) begin
      chan_next = '1;
    end else begin
      chan_next = recip_prod[23:16];
    end
  end

  always_ff @(posedge clk) begin
    chan <= chan_next;
  end

endmodule
`default_nettype wire

FILE: rtl/hsl_to_rgb_converter.sv
// Top level of the pipelined HSL to RGB color converter.
//
// Usage: drive hue_angle, saturation and lightness and raise start for one
// cycle per item. busy is always low, so an item is taken on every cycle
// that start is high, back to back without gaps.
// Each result appears on red, green and blue for exactly one cycle while
// done is high, once its item has passed through all six register stages.
// Throughput is one item per clock; the six register stages are input
// conditioning, chroma multiply, the secondary-component multiply, channel
// selection and add, scaling by 255, and the final divide by 15.
// Results leave in the order items arrived. The receiver cannot stall the
// block and must take every result in the cycle that done marks it.
// A synchronous reset clears all valid bits, so no result appears for items
// that were in flight; the first item may be given in the cycle after reset.
// Hue values of 360 degrees and above wrap once; saturation and lightness
// above 1.0 are clamped.
`default_nettype none
module hsl_to_rgb_converter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [hsl2rgb_pkg::HUE_W-1:0]     hue_angle,
  input  wire logic [hsl2rgb_pkg::Q_W-1:0]       saturation,
  input  wire logic [hsl2rgb_pkg::Q_W-1:0]       lightness,
  output      logic                              done,
  output      logic [hsl2rgb_pkg::CH_W-1:0]      red,
  output      logic [hsl2rgb_pkg::CH_W-1:0]      green,
  output      logic [hsl2rgb_pkg::CH_W-1:0]      blue
);

  // Valid bits for the six stages.
  logic [5:0] vld;

  // Stage 1: conditioned inputs.
  logic [hsl2rgb_pkg::HUE_W-1:0] hue1, hue1_next;
  logic [hsl2rgb_pkg::Q_W-1:0]   sat1, sat1_next;
  logic [hsl2rgb_pkg::Q_W-1:0]   light1, light1_next;
  logic [hsl2rgb_pkg::Q_W-1:0]   dist1, dist1_next;
  logic [13:0]                   two_l;

  // Stage 2: chroma, sector and sector position.
  logic [hsl2rgb_pkg::C24_W-1:0] chroma2, chroma2_next;
  logic [hsl2rgb_pkg::Q_W-1:0]   light2;
  hsl2rgb_pkg::sector_t          sector2, sector2_next;
  logic [11:0]                   pos2, pos2_next;
  logic [11:0]                   frac;
  logic [hsl2rgb_pkg::Q_W-1:0]   chroma_l;

  // Stage 3: numerator terms.
  logic [hsl2rgb_pkg::TERM_W-1:0]      cn3, cn3_next;
  logic [hsl2rgb_pkg::TERM_W-1:0]      xn3, xn3_next;
  logic signed [hsl2rgb_pkg::MN_W-1:0] mn3, mn3_next;
  hsl2rgb_pkg::sector_t                sector3;
  logic [hsl2rgb_pkg::TERM_W-1:0]      light_term;
  logic [hsl2rgb_pkg::TERM_W-1:0]      half_term;

  // Stage 4: channel numerators.
  hsl2rgb_pkg::num_t rn4, gn4, bn4;
  hsl2rgb_pkg::num_t rn4_next, gn4_next, bn4_next;
  logic [hsl2rgb_pkg::TERM_W-1:0] rc, gc, bc;

  assign busy = 1'b0;
  assign done = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  always_comb begin
    if (hue_angle >= hsl2rgb_pkg::HUE_FULL) begin
      hue1_next = hue_angle - hsl2rgb_pkg::HUE_FULL;
    end else begin
      hue1_next = hue_angle;
    end
    sat1_next   = (saturation > hsl2rgb_pkg::Q_ONE) ? hsl2rgb_pkg::Q_ONE : saturation;
    light1_next = (lightness > hsl2rgb_pkg::Q_ONE) ? hsl2rgb_pkg::Q_ONE : lightness;
    two_l       = {light1_next, 1'b0};
    if (two_l >= 14'(hsl2rgb_pkg::Q_ONE)) begin
      dist1_next = hsl2rgb_pkg::Q_W'(two_l - 14'(hsl2rgb_pkg::Q_ONE));
    end else begin
      dist1_next = hsl2rgb_pkg::Q_W'(14'(hsl2rgb_pkg::Q_ONE) - two_l);
    end
  end

  always_ff @(posedge clk) begin
    hue1   <= hue1_next;
    sat1   <= sat1_next;
    light1 <= light1_next;
    dist1  <= dist1_next;
  end

  // The sector comes from parallel compares against the sector boundaries.
  always_comb begin
    chroma_l     = hsl2rgb_pkg::Q_ONE - dist1;
    chroma2_next = hsl2rgb_pkg::C24_W'(chroma_l) * hsl2rgb_pkg::C24_W'(sat1);
    if (hue1 < 15'd3840) begin
      sector2_next = hsl2rgb_pkg::SEC_RED_YEL;
      frac         = 12'(hue1);
    end else if (hue1 < 15'd7680) begin
      sector2_next = hsl2rgb_pkg::SEC_YEL_GRN;
      frac         = 12'(hue1 - 15'd3840);
    end else if (hue1 < 15'd11520) begin
      sector2_next = hsl2rgb_pkg::SEC_GRN_CYAN;
      frac         = 12'(hue1 - 15'd7680);
    end else if (hue1 < 15'd15360) begin
      sector2_next = hsl2rgb_pkg::SEC_CYAN_BLUE;
      frac         = 12'(hue1 - 15'd11520);
    end else if (hue1 < 15'd19200) begin
      sector2_next = hsl2rgb_pkg::SEC_BLUE_MAG;
      frac         = 12'(hue1 - 15'd15360);
    end else begin
      sector2_next = hsl2rgb_pkg::SEC_MAG_RED;
      frac         = 12'(hue1 - 15'd19200);
    end
    // In odd sectors the secondary component falls across the sector.
    if (sector2_next[0]) begin
      pos2_next = hsl2rgb_pkg::HUE_SECTOR - frac;
    end else begin
      pos2_next = frac;
    end
  end

  always_ff @(posedge clk) begin
    chroma2 <= chroma2_next;
    light2  <= light1;
    sector2 <= sector2_next;
    pos2    <= pos2_next;
  end

  always_comb begin
    cn3_next   = hsl2rgb_pkg::TERM_W'(chroma2) * hsl2rgb_pkg::CHROMA_K;
    xn3_next   = hsl2rgb_pkg::TERM_W'(chroma2) * hsl2rgb_pkg::TERM_W'({pos2, 1'b0});
    light_term = hsl2rgb_pkg::TERM_W'(light2) * hsl2rgb_pkg::LIGHT_K;
    half_term  = hsl2rgb_pkg::TERM_W'(chroma2) * hsl2rgb_pkg::HALF_K;
    mn3_next   = $signed({1'b0, light_term}) - $signed({1'b0, half_term});
  end

  always_ff @(posedge clk) begin
    cn3     <= cn3_next;
    xn3     <= xn3_next;
    mn3     <= mn3_next;
    sector3 <= sector2;
  end

  always_comb begin
    case (sector3)
      hsl2rgb_pkg::SEC_RED_YEL: begin
        rc = cn3; gc = xn3; bc = '0;
      end
      hsl2rgb_pkg::SEC_YEL_GRN: begin
        rc = xn3; gc = cn3; bc = '0;
      end
      hsl2rgb_pkg::SEC_GRN_CYAN: begin
        rc = '0;  gc = cn3; bc = xn3;
      end
      hsl2rgb_pkg::SEC_CYAN_BLUE: begin
        rc = '0;  gc = xn3; bc = cn3;
      end
      hsl2rgb_pkg::SEC_BLUE_MAG: begin
        rc = xn3; gc = '0;  bc = cn3;
      end
      default: begin
        rc = cn3; gc = '0;  bc = xn3;
      end
    endcase
    rn4_next = $signed({2'b00, rc}) + hsl2rgb_pkg::NUM_W'(mn3);
    gn4_next = $signed({2'b00, gc}) + hsl2rgb_pkg::NUM_W'(mn3);
    bn4_next = $signed({2'b00, bc}) + hsl2rgb_pkg::NUM_W'(mn3);
  end

  always_ff @(posedge clk) begin
    rn4 <= rn4_next;
    gn4 <= gn4_next;
    bn4 <= bn4_next;
  end

  hsl2rgb_chan u_red (
    .clk  (clk),
    .num  (rn4),
    .chan (red)
  );

  hsl2rgb_chan u_green (
    .clk  (clk),
    .num  (gn4),
    .chan (green)
  );

  hsl2rgb_chan u_blue (
    .clk  (clk),
    .num  (bn4),
    .chan (blue)
  );

  // Every item taken yields exactly one result.
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done)
    else $error("item taken without a result six cycles later");

  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 6))
    else $error("result without a matching item");

  // Zero saturation gives a gray.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (start && (saturation == '0)) |-> ##6 ((red == green) && (green == blue)))
    else $error("unsaturated item did not give a gray");

  // Full lightness gives white, zero lightness gives black.
  a_white: assert property (@(posedge clk) disable iff (rst)
    (start && (lightness >= hsl2rgb_pkg::Q_ONE)) |->
      ##6 ((red == 8'hFF) && (green == 8'hFF) && (blue == 8'hFF)))
    else $error("full lightness did not give white");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && (lightness == '0)) |->
      ##6 ((red == 8'h00) && (green == 8'h00) && (blue == 8'h00)))
    else $error("zero lightness did not give black");

endmodule
`default_nettype wire
